[design/pwm_motif_scan_defines.svh]
// Assertion macros for the motif scanner.
// Assumes clk and rst_n (synchronous, active low) exist at the point of use.
`ifndef PWM_MOTIF_SCAN_DEFINES_SVH
`define PWM_MOTIF_SCAN_DEFINES_SVH

// same-cycle implication
`define PMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pmscan_pkg.sv]
// Shared types and constants for the motif scanner.
// No dependencies.
package pmscan_pkg;

  // input opcodes
  localparam logic [1:0] OP_BASE  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MOTIF_LEN = 1'b1;

  localparam int SCORE_W   = 21;
  localparam int HITPOS_W  = 16;
  localparam int SCORE_MAX = 1048575;
  localparam int SCORE_MIN = -1048576;

  // sequence position counter saturation
  localparam int MAX_SEQ    = 65536;
  localparam int SEEN_LIMIT = ((MAX_SEQ - 1) < 65535) ? (MAX_SEQ - 1) : 65535;

  localparam logic [2:0] BASE_OTHER = 3'd4;

  typedef enum logic [1:0] {
    CMD_BASE,
    CMD_LOAD,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         base;
    logic [4:0]         wpos;
    logic [1:0]         wrow;
    logic signed [15:0] wval;
  } cmd_t;

  // back-end status seen by the front end and the top level
  typedef struct packed {
    logic cmd_pop;  // command taken from the queue this cycle
    logic res_wr;   // result register loaded this cycle
  } bk_stat_t;

endpackage

[design/pmscan_front.sv]
// Front end: decodes input transactions and queues them for the back end.
// Depends on pmscan_pkg.
module pmscan_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             in_opcode,
  input  logic [2:0]             in_base,
  input  logic [4:0]             in_weight_pos,
  input  logic [1:0]             in_weight_base,
  input  logic signed [15:0]     in_weight_value,
  output logic                   cmd_valid,
  output pmscan_pkg::cmd_t       cmd,
  input  pmscan_pkg::bk_stat_t   bk_stat
);

  pmscan_pkg::cmd_t q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  pmscan_pkg::cmd_t new_cmd;
  logic             known_op;
  logic             enq;
  logic             deq;

  always_comb begin
    new_cmd.base = in_base;
    new_cmd.wpos = in_weight_pos;
    new_cmd.wrow = in_weight_base;
    new_cmd.wval = in_weight_value;
    new_cmd.kind = pmscan_pkg::CMD_BASE;
    known_op     = 1'b1;
    unique case (in_opcode)
      pmscan_pkg::OP_BASE:  new_cmd.kind = pmscan_pkg::CMD_BASE;
      pmscan_pkg::OP_LOAD:  new_cmd.kind = pmscan_pkg::CMD_LOAD;
      pmscan_pkg::OP_START: new_cmd.kind = pmscan_pkg::CMD_START;
      default:              known_op     = 1'b0;  // unused opcode: dropped
    endcase
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign enq       = push && !full && known_op;
  assign deq       = bk_stat.cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (enq) begin
        q_r[wr_ptr_r] <= new_cmd;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (enq && !deq) begin
        count_r <= count_r + 2'd1;
      end else if (deq && !enq) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[design/pmscan_back.sv]
// Back end: weight table, base window, scoring sequencer and result register.
// Depends on pmscan_pkg.
module pmscan_back #(
  parameter int MAX_MOTIF = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  input  pmscan_pkg::cmd_t                    cmd,
  output pmscan_pkg::bk_stat_t                bk_stat,
  input  logic signed [pmscan_pkg::SCORE_W-1:0] threshold,
  input  logic [$clog2(MAX_MOTIF+1)-1:0]      len_act,
  output logic                                res_valid,
  input  logic                                pop,
  output logic [pmscan_pkg::HITPOS_W-1:0]     res_pos,
  output logic signed [pmscan_pkg::SCORE_W-1:0] res_score
);

  localparam int LEN_W  = $clog2(MAX_MOTIF + 1);
  localparam int POS_W  = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;
  localparam int ADDR_W = POS_W + 2;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int ACC_W  = 17 + POS_W;

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_TAIL, S_DONE} state_t;

  state_t                     state_r;
  logic [2:0]                 win_r [MAX_MOTIF];
  logic [15:0]                seen_r;
  logic [POS_W-1:0]           j_r;
  logic [POS_W-1:0]           k_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       rd_pend_r;
  logic                       rd_use_r;
  logic signed [15:0]         rd_data_r;
  logic signed [15:0]         mem [DEPTH];
  logic                       out_valid_r;
  logic [15:0]                out_pos_r;
  logic signed [pmscan_pkg::SCORE_W-1:0] out_score_r;

  logic                       take;
  logic [15:0]                seen_nxt;
  logic [2:0]                 cur_b;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       wt_we;
  logic signed [31:0]         acc_ext;
  logic signed [pmscan_pkg::SCORE_W-1:0] score;
  logic                       hit;
  logic                       res_wr;
  logic [POS_W-1:0]           last_j;

  assign take     = (state_r == S_IDLE) && cmd_valid;
  assign seen_nxt = (seen_r < 16'(pmscan_pkg::SEEN_LIMIT)) ? seen_r + 16'd1 : seen_r;
  assign cur_b    = win_r[k_r];
  assign rd_addr  = {cur_b[1:0], j_r};
  assign wr_addr  = {cmd.wrow, POS_W'(cmd.wpos)};
  assign wt_we    = take && (cmd.kind == pmscan_pkg::CMD_LOAD) && (32'(cmd.wpos) < MAX_MOTIF);
  assign last_j   = POS_W'(len_act - LEN_W'(1));

  // saturate to the score range, then compare
  always_comb begin
    acc_ext = 32'(acc_r);
    if (acc_ext > pmscan_pkg::SCORE_MAX) begin
      score = pmscan_pkg::SCORE_W'(pmscan_pkg::SCORE_MAX);
    end else if (acc_ext < pmscan_pkg::SCORE_MIN) begin
      score = pmscan_pkg::SCORE_W'(pmscan_pkg::SCORE_MIN);
    end else begin
      score = pmscan_pkg::SCORE_W'(acc_ext);
    end
  end

  assign hit    = (score >= threshold);
  assign res_wr = (state_r == S_DONE) && hit && (!out_valid_r || pop);

  assign bk_stat.cmd_pop = take;
  assign bk_stat.res_wr  = res_wr;
  assign res_valid       = out_valid_r;
  assign res_pos         = out_pos_r;
  assign res_score       = out_score_r;

  // weight table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wt_we) begin
      mem[wr_addr] <= cmd.wval;
    end
    if (state_r == S_SUM) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= 16'd0;
      rd_pend_r   <= 1'b0;
      for (int i = 0; i < MAX_MOTIF; i++) begin
        win_r[i] <= pmscan_pkg::BASE_OTHER;
      end
    end else begin
      rd_pend_r <= (state_r == S_SUM);
      rd_use_r  <= !cur_b[2];
      if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (rd_pend_r && rd_use_r) begin
        acc_r <= acc_r + ACC_W'(rd_data_r);
      end

      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.kind)
              pmscan_pkg::CMD_START: begin
                seen_r <= 16'd0;
                for (int i = 0; i < MAX_MOTIF; i++) begin
                  win_r[i] <= pmscan_pkg::BASE_OTHER;
                end
              end
              pmscan_pkg::CMD_BASE: begin
                win_r[0] <= cmd.base;
                for (int i = 1; i < MAX_MOTIF; i++) begin
                  win_r[i] <= win_r[i-1];
                end
                seen_r <= seen_nxt;
                if (seen_nxt >= 16'(len_act)) begin
                  state_r <= S_SUM;
                  j_r     <= '0;
                  k_r     <= last_j;
                  acc_r   <= '0;
                end
              end
              default: ;  // loads handled by the table write port
            endcase
          end
        end
        S_SUM: begin
          // j walks motif positions, k the window from the oldest base
          j_r <= j_r + POS_W'(1);
          k_r <= k_r - POS_W'(1);
          if (j_r == last_j) begin
            state_r <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!hit) begin
            state_r <= S_IDLE;
          end else if (res_wr) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= seen_r - 16'(len_act);
            out_score_r <= score;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/pwm_motif_scan.sv]
// Top level of the position weight matrix motif scanner.
// Depends on pmscan_pkg, pmscan_front, pmscan_back, pwm_motif_scan_defines.svh.

// Motif scanner over a DNA base stream. Weight loads fill a 4 x MAX_MOTIF table
// of signed Q7.8 log-odds weights; a start item clears the base window and the
// position counter; each base item shifts into the window and, once
// motif_length bases of the sequence have arrived, the window is scored and a
// hit (start position, Q12.8 score saturated to 21 bits) is queued if the
// score reaches threshold. The position counter saturates at 65535.
// Timing: the front end takes one transaction per cycle into a two-entry
// command queue; push sees full only when that queue is full. The back end
// takes one command at a time; a load, a start, or a base that does not yet
// fill the window is done in the cycle that takes it. A scored base then
// walks one motif position per cycle, since the weight table has a single
// read port, then passes through the registered read data and the
// saturate/compare step. Results sit in a one-entry output register; the
// back end only waits on it when a new hit is ready while an old one is
// still unread. Unloaded weights read as garbage. The user must write
// configuration only while the block is idle; the block does not enforce it.
`include "pwm_motif_scan_defines.svh"

module pwm_motif_scan #(
  parameter int MAX_MOTIF = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_opcode,
  input  logic [2:0]          in_base,
  input  logic [4:0]          in_weight_pos,
  input  logic [1:0]          in_weight_base,
  input  logic signed [15:0]  in_weight_value,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output logic [15:0]         out_hit_position,
  output logic signed [20:0]  out_hit_score,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [20:0]         cfg_data
);

  localparam int LEN_W = $clog2(MAX_MOTIF + 1);

  logic signed [20:0]   threshold_r;
  logic [5:0]           motif_len_r;
  logic [LEN_W-1:0]     len_act;

  logic                 cmd_valid;
  pmscan_pkg::cmd_t     cmd;
  pmscan_pkg::bk_stat_t bk_stat;
  logic                 res_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      motif_len_r <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmscan_pkg::REG_THRESHOLD: threshold_r <= cfg_data;
        pmscan_pkg::REG_MOTIF_LEN: motif_len_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // length zero acts as one, anything past MAX_MOTIF as MAX_MOTIF
  always_comb begin
    priority if (motif_len_r == 6'd0) begin
      len_act = LEN_W'(1);
    end else if (32'(motif_len_r) > MAX_MOTIF) begin
      len_act = LEN_W'(MAX_MOTIF);
    end else begin
      len_act = LEN_W'(motif_len_r);
    end
  end

  pmscan_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_base         (in_base),
    .in_weight_pos   (in_weight_pos),
    .in_weight_base  (in_weight_base),
    .in_weight_value (in_weight_value),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .bk_stat         (bk_stat)
  );

  pmscan_back #(
    .MAX_MOTIF (MAX_MOTIF)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .bk_stat   (bk_stat),
    .threshold (threshold_r),
    .len_act   (len_act),
    .res_valid (res_valid),
    .pop       (pop),
    .res_pos   (out_hit_position),
    .res_score (out_hit_score)
  );

  assign empty = !res_valid;

  // a new hit never lands on an unread result
  `PMS_ASSERT_NOW(a_no_overwrite, bk_stat.res_wr, empty || pop, "hit overwrote unread result")
  // a loaded hit is visible next cycle
  `PMS_ASSERT_NEXT(a_res_shown, bk_stat.res_wr, !empty, "hit not presented")
  // a popped result without a replacement leaves the output empty
  `PMS_ASSERT_NEXT(a_pop_drains, pop && !empty && !bk_stat.res_wr, empty, "result repeated")
  // back end only takes commands that exist
  `PMS_ASSERT_NOW(a_cmd_pop_valid, bk_stat.cmd_pop, cmd_valid, "pop from empty command queue")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the pwm_motif_scan motif scanner.
// Depends on pmscan_pkg and the pwm_motif_scan RTL; needs no files or arguments.
// Drives random and directed traffic and checks every hit against a local model.
module testbench;

  localparam int WIN_DEPTH = 32;               // MAX_MOTIF of the instance
  localparam logic [1:0] OP_NONE = 2'd3;       // unused opcode, block ignores it
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam int CYCLE_LIMIT = 2_000_000;      // watchdog bound on the whole run
  localparam int DRAIN_CYCLES = 120;           // two queued commands plus a full window
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [15:0]        pos;
    logic signed [20:0] score;
  } hit_t;

  // Local model of the scanner plus the queue of hits still owed by the block.
  class motif_scoreboard;
    logic signed [15:0] weights [4][WIN_DEPTH];
    logic [2:0]         window [WIN_DEPTH];    // newest base at index 0
    int unsigned        seen;
    logic signed [20:0] thresh;
    logic [5:0]         mlen;
    hit_t               hits_due [$];
    int                 mismatches;

    function new();
      thresh = '0;
      mlen = 6'd1;
      seen = 0;
      mismatches = 0;
      foreach (window[i]) window[i] = pmscan_pkg::BASE_OTHER;
      foreach (weights[r, p]) weights[r][p] = '0;
    endfunction

    function void write_reg(logic idx, logic [20:0] data);
      if (idx == pmscan_pkg::REG_THRESHOLD) thresh = data;
      else mlen = data[5:0];
    endfunction

    // Called once per accepted input transaction.
    function void note_input(logic [1:0] op, logic [2:0] b, logic [4:0] wp,
                             logic [1:0] wr, logic signed [15:0] wv);
      int unsigned span;
      longint      sum;
      logic [2:0]  held;
      hit_t        h;
      if (op == pmscan_pkg::OP_START) begin
        foreach (window[i]) window[i] = pmscan_pkg::BASE_OTHER;
        seen = 0;
      end else if (op == pmscan_pkg::OP_LOAD) begin
        weights[wr][wp] = wv;
      end else if (op == pmscan_pkg::OP_BASE) begin
        span = (mlen == 0) ? 1 : ((mlen > WIN_DEPTH) ? WIN_DEPTH : mlen);
        for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (seen < pmscan_pkg::SEEN_LIMIT) seen++;
        if (seen >= span) begin
          sum = 0;
          // oldest base of the window lines up with motif position 0
          for (int j = 0; j < span; j++) begin
            held = window[span - 1 - j];
            if (held < pmscan_pkg::BASE_OTHER) sum += weights[held[1:0]][j];
          end
          if (sum > pmscan_pkg::SCORE_MAX) sum = pmscan_pkg::SCORE_MAX;
          if (sum < pmscan_pkg::SCORE_MIN) sum = pmscan_pkg::SCORE_MIN;
          if (sum >= thresh) begin
            h.pos = 16'(seen - span);
            h.score = 21'(sum);
            hits_due = {hits_due, h};
          end
        end
      end
    endfunction

    // Called once per accepted result transaction.
    function void check_result(logic [15:0] pos, logic signed [20:0] score);
      hit_t want;
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected hit: pos %0d score %0d", pos, score);
        return;
      end
      want = hits_due.pop_front();
      if (want.pos !== pos || want.score !== score) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hit mismatch: expected pos %0d score %0d, got pos %0d score %0d",
                   want.pos, $signed(want.score), pos, score);
      end
    endfunction

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [1:0]         in_opcode;
  logic [2:0]         in_base;
  logic [4:0]         in_weight_pos;
  logic [1:0]         in_weight_base;
  logic signed [15:0] in_weight_value;
  logic               empty;
  logic               pop;
  logic [15:0]        out_hit_position;
  logic signed [20:0] out_hit_score;
  logic               cfg_we;
  logic               cfg_index;
  logic [20:0]        cfg_data;

  motif_scoreboard sb;
  bit              idle_on;      // random gaps on both sides when set
  int              hold_req;     // receiver hold-off request, in cycles
  int              cycle_count;

  pwm_motif_scan #(.MAX_MOTIF(WIN_DEPTH)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_base          (in_base),
    .in_weight_pos    (in_weight_pos),
    .in_weight_base   (in_weight_base),
    .in_weight_value  (in_weight_value),
    .empty            (empty),
    .pop              (pop),
    .out_hit_position (out_hit_position),
    .out_hit_score    (out_hit_score),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitors sample at the edge, before any testbench NBA lands, so the
  // handshake seen here is exactly the one the block saw.
  always @(posedge clk) begin
    if (rst_n && push && !full)
      sb.note_input(in_opcode, in_base, in_weight_pos, in_weight_base, in_weight_value);
    if (rst_n && pop && !empty)
      sb.check_result(out_hit_position, out_hit_score);
  end

  // Result side: random stall before each pop, plus a long hold-off on request.
  initial begin
    int stall;
    int held_off;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        held_off = hold_req;
        hold_req = 0;
        pop <= 1'b0;
        repeat (held_off) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty && hold_req == 0);
    end
  end

  // One input transaction; push stays high after acceptance so back-to-back
  // items need no extra assignment in the same step.
  task automatic offer_item(input logic [1:0] op, input logic [2:0] b,
                            input logic [4:0] wp, input logic [1:0] wr,
                            input logic [15:0] wv);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_opcode <= op;
    in_base <= b;
    in_weight_pos <= wp;
    in_weight_base <= wr;
    in_weight_value <= wv;
    do @(posedge clk); while (full);
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic send_base(input logic [2:0] b);
    offer_item(pmscan_pkg::OP_BASE, b, 5'($urandom), 2'($urandom), 16'($urandom));
  endtask

  task automatic send_load(input logic [4:0] wp, input logic [1:0] wr, input logic [15:0] wv);
    offer_item(pmscan_pkg::OP_LOAD, 3'($urandom), wp, wr, wv);
  endtask

  task automatic send_start();
    offer_item(pmscan_pkg::OP_START, 3'($urandom), 5'($urandom), 2'($urandom),
               16'($urandom));
  endtask

  task automatic send_noop();
    offer_item(OP_NONE, 3'($urandom), 5'($urandom), 2'($urandom), 16'($urandom));
  endtask

  // Mostly real bases, sometimes the "other" codes four to seven.
  function automatic logic [2:0] any_base();
    return ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
  endfunction

  // Stop offering, wait for every owed hit, then let the back end drain
  // work that produces no hit (loads, starts, short windows).
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; drops cfg_we again before returning so writes never overlap.
  task automatic write_reg(input logic idx, input logic [20:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Full weight table so no scored window ever reads an unloaded entry.
  task automatic load_random_table();
    for (int r = 0; r < 4; r++)
      for (int p = 0; p < WIN_DEPTH; p++)
        send_load(5'(p), 2'(r), 16'($urandom));
  endtask

  task automatic fill_row(input logic [1:0] row, input logic [15:0] wv);
    for (int p = 0; p < WIN_DEPTH; p++) send_load(5'(p), row, wv);
  endtask

  // Random traffic; start_pct sets how often a new sequence begins.
  // Ignored opcodes do not count toward n.
  task automatic run_mix(input int n, input int start_pct);
    int sent;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < start_pct) begin
        send_start();
        sent++;
      end else if (pick < start_pct + 8) begin
        send_load(5'($urandom), 2'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 97) begin
        send_base(any_base());
        sent++;
      end else begin
        send_noop();
      end
    end
  endtask

  initial begin
    int th_list [NUM_PHASES];
    int len_list [NUM_PHASES];

    sb = new();
    cycle_count <= 0;
    idle_on = 1'b1;
    hold_req = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_opcode <= pmscan_pkg::OP_BASE;
    in_base <= BASE_A;
    in_weight_pos <= '0;
    in_weight_base <= '0;
    in_weight_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= pmscan_pkg::REG_THRESHOLD;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_random_table();

    // Directed: reset settings (threshold 0, length 1), every base code,
    // the ignored opcode, a start, and weight extremes at positions 0 and 31.
    send_start();
    for (int b = 0; b < 8; b++) send_base(3'(b));
    send_noop();
    send_load(5'd0, BASE_A[1:0], 16'sh8000);
    send_base(BASE_A);
    send_load(5'd0, BASE_A[1:0], 16'sh7fff);
    send_base(BASE_A);
    send_load(5'd31, BASE_T[1:0], 16'sh8000);
    send_start();
    send_base(BASE_T);
    send_base(BASE_A);

    // Random phases over threshold/length settings, including length zero,
    // lengths past the window depth and both threshold extremes.
    th_list = '{pmscan_pkg::SCORE_MIN, 0, -30000, pmscan_pkg::SCORE_MAX, 40000, 0, -5000, 0};
    len_list = '{0, 1, 5, 32, 3, 12, 40, 1};
    th_list[NUM_PHASES-1] = int'($urandom_range(0, 200000)) - 100000;
    len_list[NUM_PHASES-1] = $urandom_range(1, 63);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      idle_on = (ph % 3 != 2);   // every third phase runs flat out
      write_reg(pmscan_pkg::REG_THRESHOLD, 21'(th_list[ph]));
      write_reg(pmscan_pkg::REG_MOTIF_LEN, 21'(len_list[ph]));
      run_mix(40, (len_list[ph] > 8) ? 1 : 4);
    end

    // Back-pressure: every base hits while the receiver holds off, so the
    // result register and command queue fill and full must assert.
    settle();
    idle_on = 1'b0;
    write_reg(pmscan_pkg::REG_THRESHOLD, 21'(pmscan_pkg::SCORE_MIN));
    write_reg(pmscan_pkg::REG_MOTIF_LEN, 21'd1);
    hold_req = 300;
    repeat (40) send_base(any_base());

    // Score extremes: full-length window of all-max or all-min weights.
    // Length 63 exercises the clamp down to the window depth.
    settle();
    idle_on = 1'b1;
    write_reg(pmscan_pkg::REG_THRESHOLD, 21'(pmscan_pkg::SCORE_MIN));
    write_reg(pmscan_pkg::REG_MOTIF_LEN, 21'd63);
    fill_row(BASE_A[1:0], 16'sh7fff);
    fill_row(BASE_T[1:0], 16'sh8000);
    send_start();
    repeat (WIN_DEPTH) send_base(BASE_A);
    repeat (WIN_DEPTH) send_base(BASE_T);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
